// File: hdl/ebnfgt_pkg.sv
`timescale 1ns / 1ps
// Shared types and codes for the grammar tokenizer.
// No dependencies; imported by every module of the block.
package ebnfgt_pkg;

	// token kinds
	localparam logic [3:0] KIND_EOF     = 4'd0;
	localparam logic [3:0] KIND_IDENT   = 4'd1;
	localparam logic [3:0] KIND_LITERAL = 4'd2;
	localparam logic [3:0] KIND_EQUAL   = 4'd3;
	localparam logic [3:0] KIND_SEMI    = 4'd4;
	localparam logic [3:0] KIND_BAR     = 4'd5;
	localparam logic [3:0] KIND_LPAREN  = 4'd6;
	localparam logic [3:0] KIND_RPAREN  = 4'd7;
	localparam logic [3:0] KIND_LBRACK  = 4'd8;
	localparam logic [3:0] KIND_RBRACK  = 4'd9;
	localparam logic [3:0] KIND_LBRACE  = 4'd10;
	localparam logic [3:0] KIND_RBRACE  = 4'd11;
	localparam logic [3:0] KIND_ERROR   = 4'd12;

	// scan modes
	localparam logic [1:0] MODE_IDLE    = 2'd0;
	localparam logic [1:0] MODE_IDENT   = 2'd1;
	localparam logic [1:0] MODE_LITERAL = 2'd2;

	// characters
	localparam logic [7:0] CH_NUL    = 8'h00;
	localparam logic [7:0] CH_EQUAL  = 8'h3D;
	localparam logic [7:0] CH_SEMI   = 8'h3B;
	localparam logic [7:0] CH_BAR    = 8'h7C;
	localparam logic [7:0] CH_LPAREN = 8'h28;
	localparam logic [7:0] CH_RPAREN = 8'h29;
	localparam logic [7:0] CH_LBRACK = 8'h5B;
	localparam logic [7:0] CH_RBRACK = 8'h5D;
	localparam logic [7:0] CH_LBRACE = 8'h7B;
	localparam logic [7:0] CH_RBRACE = 8'h7D;
	localparam logic [7:0] CH_DQUOTE = 8'h22;
	localparam logic [7:0] CH_SQUOTE = 8'h27;

	// result queue depth, power of two, at least 4
	localparam int RESULT_DEPTH = 8;

	typedef struct packed {
		logic [3:0] kind;
		logic [7:0] lexeme;
		logic       is_char;
		logic       last;
	} result_t;

	// everything one byte produces
	typedef struct packed {
		logic [1:0] mode;
		logic       quote_single;
		logic [1:0] cnt;
		result_t    res1;
		result_t    res0;
	} lex_out_t;

endpackage

// File: hdl/ebnfgt_lex.sv
`timescale 1ns / 1ps
// Combinational scanner step: one byte plus scan state in, next state and up to two words out.
// Depends on ebnfgt_pkg.
module ebnfgt_lex import ebnfgt_pkg::*; (
	input  logic [1:0] mode,
	input  logic       quote_single,
	input  logic [7:0] text_byte,
	output lex_out_t   lex
);

	logic       is_letter;
	logic       is_digit;
	logic       is_space;
	logic [3:0] punct;
	logic       idle_has;
	result_t    idle_res;
	logic [1:0] idle_mode;
	logic       idle_quote;
	logic [7:0] close_ch;

	assign is_letter = (text_byte >= 8'h41 && text_byte <= 8'h5A) ||
	                   (text_byte >= 8'h61 && text_byte <= 8'h7A);
	assign is_digit  = text_byte >= 8'h30 && text_byte <= 8'h39;
	assign is_space  = text_byte == 8'h20 || (text_byte >= 8'h09 && text_byte <= 8'h0D);
	assign close_ch  = quote_single ? CH_SQUOTE : CH_DQUOTE;

	always_comb begin
		unique case (text_byte)
			CH_EQUAL:  punct = KIND_EQUAL;
			CH_SEMI:   punct = KIND_SEMI;
			CH_BAR:    punct = KIND_BAR;
			CH_LPAREN: punct = KIND_LPAREN;
			CH_RPAREN: punct = KIND_RPAREN;
			CH_LBRACK: punct = KIND_LBRACK;
			CH_RBRACK: punct = KIND_RBRACK;
			CH_LBRACE: punct = KIND_LBRACE;
			CH_RBRACE: punct = KIND_RBRACE;
			default:   punct = KIND_ERROR;
		endcase
	end

	// between tokens: at most one word
	always_comb begin
		idle_has   = 1'b1;
		idle_res   = '{kind: KIND_EOF, lexeme: 8'd0, is_char: 1'b0, last: 1'b0};
		idle_mode  = MODE_IDLE;
		idle_quote = quote_single;
		if (text_byte == CH_NUL) begin
			idle_res.kind = KIND_EOF;
		end else if (is_space) begin
			idle_has = 1'b0;
		end else if (is_letter) begin
			idle_mode = MODE_IDENT;
			idle_res  = '{kind: KIND_IDENT, lexeme: text_byte, is_char: 1'b1, last: 1'b0};
		end else if (text_byte == CH_DQUOTE || text_byte == CH_SQUOTE) begin
			idle_has   = 1'b0;
			idle_mode  = MODE_LITERAL;
			idle_quote = text_byte == CH_SQUOTE;
		end else begin
			idle_res.kind = punct;
		end
	end

	always_comb begin
		lex              = '0;
		lex.mode         = mode;
		lex.quote_single = quote_single;
		if (mode == MODE_IDENT) begin
			if (is_letter || is_digit) begin
				lex.cnt  = 2'd1;
				lex.res0 = '{kind: KIND_IDENT, lexeme: text_byte, is_char: 1'b1, last: 1'b1};
			end else begin
				// close the identifier, then treat the byte as between tokens
				lex.res0         = '{kind: KIND_IDENT, lexeme: 8'd0, is_char: 1'b0,
				                     last: !idle_has};
				lex.res1         = idle_res;
				lex.res1.last    = 1'b1;
				lex.cnt          = idle_has ? 2'd2 : 2'd1;
				lex.mode         = idle_mode;
				lex.quote_single = idle_quote;
			end
		end else if (mode == MODE_LITERAL) begin
			if (text_byte == close_ch) begin
				lex.cnt  = 2'd1;
				lex.res0 = '{kind: KIND_LITERAL, lexeme: 8'd0, is_char: 1'b0, last: 1'b1};
				lex.mode = MODE_IDLE;
			end else if (text_byte == CH_NUL) begin
				// literal cut short: complete it, then end of input
				lex.cnt  = 2'd2;
				lex.res0 = '{kind: KIND_LITERAL, lexeme: 8'd0, is_char: 1'b0, last: 1'b0};
				lex.res1 = '{kind: KIND_EOF, lexeme: 8'd0, is_char: 1'b0, last: 1'b1};
				lex.mode = MODE_IDLE;
			end else begin
				lex.cnt  = 2'd1;
				lex.res0 = '{kind: KIND_LITERAL, lexeme: text_byte, is_char: 1'b1, last: 1'b1};
			end
		end else begin
			lex.cnt          = idle_has ? 2'd1 : 2'd0;
			lex.res0         = idle_res;
			lex.res0.last    = 1'b1;
			lex.mode         = idle_mode;
			lex.quote_single = idle_quote;
		end
	end

endmodule

// File: hdl/ebnfgt_fifo.sv
`timescale 1ns / 1ps
// Result queue: takes zero, one or two words per cycle, gives one per cycle when popped.
// Depends on ebnfgt_pkg.
module ebnfgt_fifo import ebnfgt_pkg::*; #(
	parameter int DEPTH = RESULT_DEPTH
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic [1:0]               push_cnt,
	input  result_t                  push0,
	input  result_t                  push1,
	input  logic                     pop,
	output result_t                  head,
	output logic [$clog2(DEPTH):0]   count
);

	localparam int PTR_W = $clog2(DEPTH);

	result_t            mem_q [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [PTR_W:0]     count_q;
	logic [PTR_W-1:0]   wr_next;

	assign wr_next = wr_ptr_q + PTR_W'(1);
	assign head    = mem_q[rd_ptr_q];
	assign count   = count_q;

	always_ff @(posedge clk) begin
		if (push_cnt != 2'd0) begin
			mem_q[wr_ptr_q] <= push0;
		end
		if (push_cnt == 2'd2) begin
			mem_q[wr_next] <= push1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + PTR_W'(push_cnt);
			rd_ptr_q <= rd_ptr_q + PTR_W'(pop);
			count_q  <= count_q + (PTR_W+1)'(push_cnt) - (PTR_W+1)'(pop);
		end
	end

endmodule

// File: hdl/ebnf_grammar_tokenizer.sv
`timescale 1ns / 1ps
// Top level of the grammar tokenizer: input register, scanner step, result queue.
// Depends on ebnfgt_pkg, ebnfgt_lex and ebnfgt_fifo.

// The tokenizer takes one grammar byte per word on the slave side and can accept a
// new byte in every cycle. A zero byte ends the input and yields an eof token; the
// scanner is idle again after it. Identifier and literal text comes out one character
// per word (m_tuser high, kind 1 or 2), followed by one completion word (m_tuser low)
// per token; punctuation, eof and error tokens are single completion words. m_tlast
// marks the final word caused by one input byte; a byte may cause none, one or two.
// An accepted byte waits in the input register; the combinational scanner step then
// writes the words it causes into the result queue. Throughput is one
// byte per cycle while the master side drains one word per cycle; the queue of
// FIFO_DEPTH words absorbs the occasional two-word byte, and s_tready drops only
// while the queue cannot take two more words for the byte in flight and the next one.
module ebnf_grammar_tokenizer import ebnfgt_pkg::*; #(
	parameter int FIFO_DEPTH = RESULT_DEPTH  // power of two, at least 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] text_byte
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // [3:0] token_kind, [11:4] lexeme_byte, [15:12] zero
	output logic        m_tuser,   // [0] is_lexeme_char
	output logic        m_tlast    // last_of_item
);

	localparam int CNT_W = $clog2(FIFO_DEPTH) + 1;

	// input register
	logic             valid_s1;
	logic [7:0]       byte_s1;

	// scan state
	logic [1:0]       mode_q;
	logic             quote_q;

	lex_out_t         lex;
	result_t          head;
	logic [CNT_W-1:0] count;
	logic [CNT_W:0]   reserved;
	logic             pop;
	logic [1:0]       push_cnt;

	// Admit a byte only if the queue can take two words from the byte already in the
	// input register and two from the new one.
	assign reserved = {1'b0, count} + (valid_s1 ? (CNT_W+1)'(2) : (CNT_W+1)'(0))
	                  + (CNT_W+1)'(2);
	assign s_tready = reserved <= (CNT_W+1)'(FIFO_DEPTH);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= s_tvalid && s_tready;
		end
	end

	// payload: hold the accepted byte
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1 <= s_tdata;
		end
	end

	ebnfgt_lex u_lex (
		.mode         (mode_q),
		.quote_single (quote_q),
		.text_byte    (byte_s1),
		.lex          (lex)
	);

	// advance scan state once per byte in the input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_IDLE;
			quote_q <= 1'b0;
		end else if (valid_s1) begin
			mode_q  <= lex.mode;
			quote_q <= lex.quote_single;
		end
	end

	assign push_cnt = valid_s1 ? lex.cnt : 2'd0;
	assign pop      = m_tvalid && m_tready;

	ebnfgt_fifo #(
		.DEPTH (FIFO_DEPTH)
	) u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push_cnt (push_cnt),
		.push0    (lex.res0),
		.push1    (lex.res1),
		.pop      (pop),
		.head     (head),
		.count    (count)
	);

	assign m_tvalid = count != '0;
	assign m_tdata  = {4'd0, head.lexeme, head.kind};
	assign m_tuser  = head.is_char;
	assign m_tlast  = head.last;

endmodule

// File: hdl/ebnfgt_chk.sv
`timescale 1ns / 1ps
// Port-level checker for the grammar tokenizer, bound to the top level.
// Depends on ebnfgt_pkg and ebnf_grammar_tokenizer.
module ebnfgt_chk import ebnfgt_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [15:0] m_tdata,
	input logic        m_tuser,
	input logic        m_tlast
);

	// a stalled word stays offered
	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("output word withdrawn while stalled");

	// lexeme characters belong to identifiers or literals only
	a_char_kind: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata[3:0] == KIND_IDENT || m_tdata[3:0] == KIND_LITERAL)
		else $error("lexeme character with wrong kind");

	// completion words carry no lexeme byte
	a_done_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> m_tdata[11:4] == 8'd0 && m_tdata[15:12] == 4'd0)
		else $error("completion word with nonzero data");

	// no kind beyond error
	a_kind_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[3:0] <= KIND_ERROR)
		else $error("token kind out of range");

	// nothing comes out right after reset
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		!$past(arst_n) |-> !m_tvalid)
		else $error("output word right after reset");

endmodule

bind ebnf_grammar_tokenizer ebnfgt_chk u_chk (.*);

// File: tb/testbench.sv
`timescale 1ns / 1ps
// Self-checking bench for ebnf_grammar_tokenizer: directed and random grammar text is
// streamed in, and every output word is checked against a token predictor kept here.
// Depends on ebnfgt_pkg and the tokenizer RTL.
module testbench;
	import ebnfgt_pkg::*;

	localparam int CYCLE_LIMIT = 400000;

	// receiver stall styles
	localparam int RX_OPEN    = 0;
	localparam int RX_RANDOM  = 1;
	localparam int RX_PATTERN = 2;
	localparam int RX_HEAVY   = 3;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;
	logic        m_tvalid;
	logic        m_tready;
	logic [15:0] m_tdata;
	logic        m_tuser;
	logic        m_tlast;

	ebnf_grammar_tokenizer DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	always #5 clk = ~clk;

	// predictor state and the words it still expects
	logic [1:0] lex_mode;
	logic       single_quoted;
	result_t    expected_words [$];

	int mismatches  = 0;
	int word_count  = 0;
	int items_sent  = 0;
	int cycle_count = 0;

	// sender burst control
	int   burst_left    = 0;
	logic sender_steady = 1'b0;

	// receiver control; hold_request is picked up by the receiver process
	int         hold_request = 0;
	int         hold_left    = 0;
	int         rx_cycle     = 0;
	int         rx_style     = RX_OPEN;
	logic [7:0] rx_mask      = 8'b1011_0111;

	logic [7:0] punct_chars [9] = '{CH_EQUAL, CH_SEMI, CH_BAR, CH_LPAREN, CH_RPAREN,
		CH_LBRACK, CH_RBRACK, CH_LBRACE, CH_RBRACE};

	function automatic logic is_alpha(input logic [7:0] c);
		return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
	endfunction

	function automatic result_t make_word(input logic [3:0] kind, input logic [7:0] lex,
			input logic is_char);
		result_t w;
		w.kind    = kind;
		w.lexeme  = lex;
		w.is_char = is_char;
		w.last    = 1'b0;
		return w;
	endfunction

	// Advance the token predictor by one byte and queue the words it causes.
	function automatic void predict_tokens(input logic [7:0] c);
		result_t    words [2];
		int         n;
		logic       from_idle;
		logic [3:0] k;
		n = 0;
		from_idle = 1'b0;
		case (lex_mode)
		MODE_IDENT: begin
			if (is_alpha(c) || (c >= "0" && c <= "9")) begin
				words[n] = make_word(KIND_IDENT, c, 1'b1);
				n = n + 1;
			end else begin
				// close the identifier, then treat the byte as if between tokens
				words[n] = make_word(KIND_IDENT, 8'h00, 1'b0);
				n = n + 1;
				from_idle = 1'b1;
			end
		end
		MODE_LITERAL: begin
			if (c == (single_quoted ? CH_SQUOTE : CH_DQUOTE)) begin
				words[n] = make_word(KIND_LITERAL, 8'h00, 1'b0);
				n = n + 1;
				lex_mode = MODE_IDLE;
			end else if (c == CH_NUL) begin
				// end of input cuts the literal short
				words[0] = make_word(KIND_LITERAL, 8'h00, 1'b0);
				words[1] = make_word(KIND_EOF, 8'h00, 1'b0);
				n = 2;
				lex_mode = MODE_IDLE;
			end else begin
				words[n] = make_word(KIND_LITERAL, c, 1'b1);
				n = n + 1;
			end
		end
		default: from_idle = 1'b1;
		endcase

		if (from_idle) begin
			lex_mode = MODE_IDLE;
			if (c == CH_NUL) begin
				words[n] = make_word(KIND_EOF, 8'h00, 1'b0);
				n = n + 1;
			end else if (c == " " || (c >= 8'd9 && c <= 8'd13)) begin
				// skip whitespace
			end else if (is_alpha(c)) begin
				lex_mode = MODE_IDENT;
				words[n] = make_word(KIND_IDENT, c, 1'b1);
				n = n + 1;
			end else if (c == CH_DQUOTE || c == CH_SQUOTE) begin
				// opening quote: no word, remember which quote closes
				lex_mode = MODE_LITERAL;
				single_quoted = (c == CH_SQUOTE);
			end else begin
				case (c)
				CH_EQUAL:  k = KIND_EQUAL;
				CH_SEMI:   k = KIND_SEMI;
				CH_BAR:    k = KIND_BAR;
				CH_LPAREN: k = KIND_LPAREN;
				CH_RPAREN: k = KIND_RPAREN;
				CH_LBRACK: k = KIND_LBRACK;
				CH_RBRACK: k = KIND_RBRACK;
				CH_LBRACE: k = KIND_LBRACE;
				CH_RBRACE: k = KIND_RBRACE;
				default:   k = KIND_ERROR;
				endcase
				words[n] = make_word(k, 8'h00, 1'b0);
				n = n + 1;
			end
		end

		for (int i = 0; i < n; i++) begin
			words[i].last = (i == n - 1);
			expected_words.push_back(words[i]);
		end
	endfunction

	task automatic report_mismatch(input string field, input logic [15:0] got,
			input logic [15:0] want);
		$display("mismatch on word %0d: %s got 0x%0h, expected 0x%0h",
			word_count, field, got, want);
		mismatches++;
	endtask

	// Offer one byte; enters and leaves at a falling edge with tvalid still high.
	task automatic send_byte(input logic [7:0] b);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(40, 1);
			gap = (sender_steady || $urandom_range(3, 0) == 0) ? 0 : $urandom_range(6, 1);
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		burst_left--;
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		do @(posedge clk); while (!s_tready);
		predict_tokens(b);
		items_sent++;
		@(negedge clk);
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			send_byte(s[i]);
	endtask

	task automatic pause_until_drained();
		s_tvalid <= 1'b0;
		while (expected_words.size() != 0)
			@(negedge clk);
	endtask

	function automatic logic [7:0] random_letter();
		logic [7:0] r;
		r = 8'($urandom_range(51, 0));
		return (r < 26) ? 8'h41 + r : 8'h61 + r - 8'd26;
	endfunction

	task automatic test_punctuation();
		send_text(";|()[]{}");
	endtask

	// identifier extremes, closed by a punctuation mark, a stray byte and end of input
	task automatic test_identifiers();
		send_text("Z0=");
		send_text("z9#");
		send_text("A");
		send_byte(CH_NUL);
	endtask

	task automatic test_literals();
		// identifier closed by an opening quote; the other quote and high bytes are text
		send_text("k'");
		send_byte(8'hFF);
		send_text("\"'");
		// empty literal
		send_text("\"\"");
		// literal cut by end of input
		send_byte(CH_DQUOTE);
		send_byte(CH_NUL);
	endtask

	task automatic test_blanks_and_strays();
		send_byte(8'd9);
		send_byte(8'd13);
		send_byte(" ");
		send_byte(8'd8);
		send_byte(8'd14);
		send_byte(8'h80);
		send_byte(CH_NUL);
	endtask

	task automatic test_noise(input int count);
		repeat (count) send_byte(8'($urandom_range(255, 0)));
	endtask

	// Mostly well-formed token streams with random content, plus some junk.
	task automatic test_random_grammar(input int count);
		int         goal;
		int         pick;
		int         len;
		logic [7:0] b;
		logic [7:0] q;
		goal = items_sent + count;
		while (items_sent < goal) begin
			pick = $urandom_range(99, 0);
			if (pick < 30) begin
				len = $urandom_range(8, 1);
				send_byte(random_letter());
				repeat (len - 1)
					send_byte(($urandom_range(2, 0) == 0)
						? 8'h30 + 8'($urandom_range(9, 0)) : random_letter());
			end else if (pick < 50) begin
				q = $urandom_range(1, 0) ? CH_SQUOTE : CH_DQUOTE;
				send_byte(q);
				repeat ($urandom_range(6, 0)) begin
					b = 8'($urandom_range(255, 1));
					if (b == q)
						b = "A";
					send_byte(b);
				end
				send_byte(($urandom_range(9, 0) == 0) ? CH_NUL : q);
			end else if (pick < 75) begin
				send_byte(punct_chars[$urandom_range(8, 0)]);
			end else if (pick < 88) begin
				send_byte($urandom_range(1, 0) ? 8'h20 : 8'd9 + 8'($urandom_range(4, 0)));
			end else if (pick < 93) begin
				send_byte(CH_NUL);
			end else begin
				send_byte(8'($urandom_range(255, 0)));
			end
		end
	endtask

	// Hold the receiver off while the sender keeps pushing, so the queue fills.
	task automatic test_backpressure();
		sender_steady = 1'b1;
		hold_request = 500;
		test_random_grammar(200);
		sender_steady = 1'b0;
	endtask

	// Let the block drain completely between short rules.
	task automatic test_drain_pause();
		repeat (4) begin
			send_text("rule = 'a' | b1 ;\n");
			send_byte(CH_NUL);
			pause_until_drained();
		end
	endtask

	// receiver: change stall style now and then, obey hold requests
	always @(negedge clk) begin
		rx_cycle++;
		if (rx_cycle % 256 == 0)
			rx_style = $urandom_range(RX_HEAVY, RX_OPEN);
		if (hold_request > 0) begin
			hold_left = hold_request;
			hold_request = 0;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else begin
			case (rx_style)
			RX_OPEN:    m_tready <= 1'b1;
			RX_RANDOM:  m_tready <= ($urandom_range(3, 0) != 0);
			RX_PATTERN: m_tready <= rx_mask[rx_cycle % 8];
			default:    m_tready <= 1'($urandom_range(1, 0));
			endcase
		end
	end

	// compare each accepted word with the oldest expectation
	always @(posedge clk) begin : check_words
		result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_words.size() == 0) begin
				report_mismatch("unexpected word", m_tdata, 16'h0);
			end else begin
				want = expected_words.pop_front();
				if (m_tdata[3:0] !== want.kind)
					report_mismatch("token_kind", 16'(m_tdata[3:0]), 16'(want.kind));
				if (m_tdata[11:4] !== want.lexeme)
					report_mismatch("lexeme_byte", 16'(m_tdata[11:4]), 16'(want.lexeme));
				if (m_tuser !== want.is_char)
					report_mismatch("is_lexeme_char", 16'(m_tuser), 16'(want.is_char));
				if (m_tlast !== want.last)
					report_mismatch("last_of_item", 16'(m_tlast), 16'(want.last));
				if (m_tdata[15:12] !== 4'h0)
					report_mismatch("tdata padding", 16'(m_tdata[15:12]), 16'h0);
			end
			word_count++;
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("FAILED: results differ");
			$finish;
		end
	end

	initial begin
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = 8'h00;
		m_tready = 1'b0;
		lex_mode = MODE_IDLE;
		single_quoted = 1'b0;
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_punctuation();
		test_identifiers();
		test_literals();
		test_blanks_and_strays();
		test_noise(300);
		test_random_grammar(600);
		test_backpressure();
		test_drain_pause();
		test_random_grammar(800);

		pause_until_drained();
		repeat (10) @(negedge clk);
		if (mismatches == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule
